### rtl/core/ust_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ust_pkg
// Shared types and constants for the unsorted set table.
// ----------------------------------------------------------------------------
package ust_pkg;

	localparam int unsigned DEPTH     = 64;
	localparam int unsigned KEY_W     = 32;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned STAT_W    = 3;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(50);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_FIND   = 3'd2,
		OP_READ   = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK       = 3'd0,
		STATUS_FULL     = 3'd1,
		STATUS_DUP      = 3'd2,
		STATUS_NOTFOUND = 3'd3,
		STATUS_OOB      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC
	} fsm_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] rd_index;
		logic             ins_en;
		logic             del_en;
		logic [IDX_W-1:0] del_pos;
	} cell_ctl_t;

endpackage

### rtl/core/ust_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ust_cell
// One table slot: holds a key, compares it, and takes its neighbor's key
// when a delete closes a gap.
// ----------------------------------------------------------------------------
module ust_cell
	import ust_pkg::*;
#(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [KEY_W-1:0] next_key,
	output logic [KEY_W-1:0] cell_key,
	output logic             match,
	output logic [KEY_W-1:0] rd_data
);

	localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(CELL_IDX);
	localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_IDX + 1);
	localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);

	logic [KEY_W-1:0] key_q;
	logic             valid;

	assign valid    = MY_POS < ctl.count;
	assign match    = valid && (key_q == ctl.key);
	assign rd_data  = (ctl.rd_index == MY_IDX) ? key_q : '0;
	assign cell_key = key_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en && (ctl.count == MY_POS)) begin
			key_q <= ctl.key;
		end else if (ctl.del_en && (MY_IDX >= ctl.del_pos) && (MY_NEXT < ctl.count)) begin
			key_q <= next_key;
		end
	end

endmodule

### rtl/core/unsorted_set_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_set_table_core
// Insertion-ordered table of unique keys built as a row of compare cells.
// A taken request passes the compare state, where the cells compare the key
// in parallel, then the execute state, which updates the row and registers
// the result. A new request may be taken in the execute state.
// The receiver cannot stall; busy is high only in the compare state.
// Reset clears the count and sets capacity to 50; key storage is not reset.
// ----------------------------------------------------------------------------
module unsorted_set_table_core
	import ust_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [KEY_W-1:0]  key,
	input  logic [IDX_W-1:0]  index,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [IDX_W-1:0]  found_index,
	output logic [KEY_W-1:0]  item,
	output logic [CNT_W-1:0]  count,
	output logic              is_empty,
	output logic              is_full
);

	fsm_t              state_q, state_d;
	logic              accept;
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  index_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  eff_cap;

	logic [DEPTH-1:0]  match;
	logic [KEY_W-1:0]  cell_key [DEPTH];
	logic [KEY_W-1:0]  rd_data  [DEPTH];
	logic              hit;
	logic [IDX_W-1:0]  pos;
	logic [KEY_W-1:0]  rd_item;

	logic              hit_s1;
	logic [IDX_W-1:0]  pos_s1;
	logic [KEY_W-1:0]  rd_item_s1;

	cell_ctl_t         ctl;
	logic              ins_en, del_en;
	status_t           stat_d;
	logic [IDX_W-1:0]  fidx_d;
	logic [KEY_W-1:0]  item_d;

	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [IDX_W-1:0]  fidx_q;
	logic [KEY_W-1:0]  item_q;
	logic [CNT_W-1:0]  count_q;
	logic              empty_q, full_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CMP;
			end
			S_CMP: begin
				busy    = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = start ? S_CMP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			key_q   <= key;
			index_q <= index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			cnt_q <= '0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			cnt_q <= cnt_d;
		end
	end

	assign eff_cap = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;

	// Cell row
	assign ctl.key      = key_q;
	assign ctl.count    = cnt_q;
	assign ctl.rd_index = index_q;
	assign ctl.ins_en   = ins_en;
	assign ctl.del_en   = del_en;
	assign ctl.del_pos  = pos_s1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_key[i+1];
		end
		ust_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.next_key (nxt),
			.cell_key (cell_key[i]),
			.match    (match[i]),
			.rd_data  (rd_data[i])
		);
	end

	// Stored keys are unique, so at most one cell matches and its
	// position is the OR of the matching indexes.
	always_comb begin
		pos     = '0;
		rd_item = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) pos = pos | IDX_W'(i);
			rd_item = rd_item | rd_data[i];
		end
	end

	assign hit = |match;

	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			hit_s1     <= hit;
			pos_s1     <= pos;
			rd_item_s1 <= rd_item;
		end
	end

	// Execute
	always_comb begin
		ins_en = 1'b0;
		del_en = 1'b0;
		stat_d = STATUS_OK;
		fidx_d = '0;
		item_d = '0;
		cnt_d  = cnt_q;
		if (state_q == S_EXEC) begin
			case (op_t'(op_q))
				OP_INSERT: begin
					if (cnt_q >= eff_cap) begin
						stat_d = STATUS_FULL;
					end else if (hit_s1) begin
						stat_d = STATUS_DUP;
					end else begin
						ins_en = 1'b1;
						cnt_d  = cnt_q + CNT_W'(1);
					end
				end
				OP_DELETE: begin
					if (!hit_s1) begin
						stat_d = STATUS_NOTFOUND;
					end else begin
						del_en = 1'b1;
						cnt_d  = cnt_q - CNT_W'(1);
					end
				end
				OP_FIND: begin
					if (hit_s1) begin
						fidx_d = pos_s1;
					end else begin
						stat_d = STATUS_NOTFOUND;
					end
				end
				OP_READ: begin
					if ({1'b0, index_q} >= cnt_q) begin
						stat_d = STATUS_OOB;
					end else begin
						item_d = rd_item_s1;
					end
				end
				OP_CLEAR: begin
					cnt_d = '0;
				end
				default: begin
					stat_d = STATUS_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_q <= stat_d;
			fidx_q   <= fidx_d;
			item_q   <= item_d;
			count_q  <= cnt_d;
			empty_q  <= (cnt_d == '0);
			full_q   <= (cnt_d >= eff_cap);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_index = fidx_q;
	assign item        = item_q;
	assign count       = count_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

`ifndef ASSERT_OFF
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> $onehot0(match))
		else $error("more than one cell matched the key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds the table depth");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EXEC) |=> $stable(cnt_q))
		else $error("entry count changed outside the execute cycle");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (count_q == cnt_q))
		else $error("reported count differs from the table count");
`endif

endmodule
